// File: hw/rtl/lasd_pkg.sv
package lasd_pkg;

   // Result kinds as they appear on the result channel.
   localparam logic [2:0] KIND_PIXEL = 3'd0;
   localparam logic [2:0] KIND_SHOW  = 3'd1;
   localparam logic [2:0] KIND_DELAY = 3'd2;
   localparam logic [2:0] KIND_FADE  = 3'd3;
   localparam logic [2:0] KIND_END   = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_STREAM_LENGTH = 2'd0;
   localparam logic [1:0] CSR_PALETTE_SIZE  = 2'd1;
   localparam logic [1:0] CSR_PIXEL_TOTAL   = 2'd2;

   // Everything one stream byte causes, in output order: an optional pixel
   // write, an optional show/delay/fade event, an optional end event.
   typedef struct packed {
      logic        has_pix;
      logic [15:0] pos;
      logic [7:0]  idx;
      logic        has_mid;
      logic [2:0]  mid_kind;
      logic [15:0] dur;
      logic        has_end;
   } bundle_type;

endpackage

// File: hw/rtl/lasd_front.sv
module lasd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            stream_byte,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_data,
   output logic                  bundle_valid,
   output lasd_pkg::bundle_type  bundle
);

   localparam logic [2:0] PH_TYPE  = 3'd0;
   localparam logic [2:0] PH_COUNT = 3'd1;
   localparam logic [2:0] PH_POS   = 3'd2;
   localparam logic [2:0] PH_INDEX = 3'd3;
   localparam logic [2:0] PH_DUR   = 3'd4;

   localparam logic [1:0] RK_I = 2'd0;
   localparam logic [1:0] RK_P = 2'd1;
   localparam logic [1:0] RK_D = 2'd2;
   localparam logic [1:0] RK_F = 2'd3;

   localparam logic [7:0] CHAR_I = 8'h49;
   localparam logic [7:0] CHAR_P = 8'h50;
   localparam logic [7:0] CHAR_D = 8'h44;
   localparam logic [7:0] CHAR_F = 8'h46;

   logic [15:0] stream_length_ff;
   logic [8:0]  palette_size_ff;
   logic [15:0] pixel_total_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  rkind_ff, rkind_in;
   logic [15:0] consumed_ff, consumed_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [15:0] counter_ff, counter_in;
   logic [15:0] acc_ff, acc_in;
   logic        hbp_ff, hbp_in;
   logic        finished_ff, finished_in;

   logic        rec_done;
   logic [15:0] rem_dec;

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_length_ff <= '0;
         palette_size_ff  <= '0;
         pixel_total_ff   <= 16'd1;
      end else if (csr_we) begin
         case (csr_index)
            lasd_pkg::CSR_STREAM_LENGTH: stream_length_ff <= csr_data;
            lasd_pkg::CSR_PALETTE_SIZE:  palette_size_ff  <= csr_data[8:0];
            lasd_pkg::CSR_PIXEL_TOTAL:   pixel_total_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      rkind_in     = rkind_ff;
      consumed_in  = consumed_ff;
      remaining_in = remaining_ff;
      counter_in   = counter_ff;
      acc_in       = acc_ff;
      hbp_in       = hbp_ff;
      finished_in  = finished_ff;
      bundle       = '0;
      rec_done     = 1'b0;
      rem_dec      = remaining_ff - 16'd1;

      if (accept && !finished_ff) begin
         if (phase_ff == PH_TYPE && consumed_ff >= stream_length_ff) begin
            bundle.has_end = 1'b1;
            finished_in    = 1'b1;
         end else begin
            if (consumed_ff != 16'hFFFF) begin
               consumed_in = consumed_ff + 16'd1;
            end
            case (phase_ff)
               PH_TYPE: begin
                  hbp_in = 1'b0;
                  if (stream_byte == CHAR_I) begin
                     rkind_in = RK_I;
                     phase_in = PH_COUNT;
                  end else if (stream_byte == CHAR_P) begin
                     rkind_in = RK_P;
                     phase_in = PH_COUNT;
                  end else if (stream_byte == CHAR_D) begin
                     rkind_in = RK_D;
                     phase_in = PH_DUR;
                  end else if (stream_byte == CHAR_F) begin
                     rkind_in = RK_F;
                     phase_in = PH_DUR;
                  end else begin
                     rec_done = 1'b1;
                  end
               end
               PH_COUNT: begin
                  if (!hbp_ff) begin
                     acc_in = {stream_byte, 8'h00};
                     hbp_in = 1'b1;
                  end else begin
                     acc_in       = {acc_ff[15:8], stream_byte};
                     hbp_in       = 1'b0;
                     remaining_in = {acc_ff[15:8], stream_byte};
                     counter_in   = '0;
                     if ({acc_ff[15:8], stream_byte} == 16'd0) begin
                        bundle.has_mid  = 1'b1;
                        bundle.mid_kind = lasd_pkg::KIND_SHOW;
                        rec_done        = 1'b1;
                     end else begin
                        phase_in = (rkind_ff == RK_P) ? PH_POS : PH_INDEX;
                     end
                  end
               end
               PH_POS: begin
                  if (pixel_total_ff > 16'd256 && !hbp_ff) begin
                     acc_in = {stream_byte, 8'h00};
                     hbp_in = 1'b1;
                  end else begin
                     acc_in   = hbp_ff ? {acc_ff[15:8], stream_byte} : {8'h00, stream_byte};
                     hbp_in   = 1'b0;
                     phase_in = PH_INDEX;
                  end
               end
               PH_INDEX: begin
                  if ({1'b0, stream_byte} < palette_size_ff) begin
                     bundle.has_pix = 1'b1;
                     bundle.pos     = (rkind_ff == RK_P) ? acc_ff : counter_ff;
                     bundle.idx     = stream_byte;
                  end
                  counter_in   = counter_ff + 16'd1;
                  remaining_in = rem_dec;
                  if (rem_dec == 16'd0) begin
                     bundle.has_mid  = 1'b1;
                     bundle.mid_kind = lasd_pkg::KIND_SHOW;
                     rec_done        = 1'b1;
                  end else begin
                     phase_in = (rkind_ff == RK_P) ? PH_POS : PH_INDEX;
                  end
               end
               PH_DUR: begin
                  if (!hbp_ff) begin
                     acc_in = {stream_byte, 8'h00};
                     hbp_in = 1'b1;
                  end else begin
                     acc_in          = {acc_ff[15:8], stream_byte};
                     hbp_in          = 1'b0;
                     bundle.has_mid  = 1'b1;
                     bundle.mid_kind = (rkind_ff == RK_F) ? lasd_pkg::KIND_FADE
                                                          : lasd_pkg::KIND_DELAY;
                     bundle.dur      = {acc_ff[15:8], stream_byte};
                     rec_done        = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_TYPE;
                  hbp_in   = 1'b0;
               end
            endcase
            if (rec_done) begin
               phase_in = PH_TYPE;
               hbp_in   = 1'b0;
               if (consumed_in >= stream_length_ff) begin
                  bundle.has_end = 1'b1;
                  finished_in    = 1'b1;
               end
            end
         end
      end
   end

   assign bundle_valid = bundle.has_pix || bundle.has_mid || bundle.has_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TYPE;
         rkind_ff     <= RK_I;
         consumed_ff  <= '0;
         remaining_ff <= '0;
         counter_ff   <= '0;
         acc_ff       <= '0;
         hbp_ff       <= 1'b0;
         finished_ff  <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rkind_ff     <= rkind_in;
         consumed_ff  <= consumed_in;
         remaining_ff <= remaining_in;
         counter_ff   <= counter_in;
         acc_ff       <= acc_in;
         hbp_ff       <= hbp_in;
         finished_ff  <= finished_in;
      end
   end

endmodule

// File: hw/rtl/lasd_queue.sv
module lasd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  lasd_pkg::bundle_type  wr_data,
   input  logic                  rd_en,
   output lasd_pkg::bundle_type  rd_data,
   output logic                  not_empty,
   output logic                  is_full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lasd_pkg::bundle_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, rptr_ff;
   logic [CNT_W-1:0] count_ff;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign rd_data   = mem_ff[rptr_ff];
   assign not_empty = (count_ff != '0);
   assign is_full   = (count_ff == CNT_W'(DEPTH));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (wr_en) begin
            wptr_ff <= ptr_next(wptr_ff);
         end
         if (rd_en) begin
            rptr_ff <= ptr_next(rptr_ff);
         end
         if (wr_en && !rd_en) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (rd_en && !wr_en) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

// File: hw/rtl/lasd_back.sv
module lasd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  lasd_pkg::bundle_type  head,
   output logic                  head_pop,
   input  logic                  pop,
   output logic                  empty,
   output logic [2:0]            kind,
   output logic [15:0]           pixel_position,
   output logic [7:0]            color_index,
   output logic [15:0]           duration_ms,
   output logic                  last
);

   logic        sent_pix_ff, sent_mid_ff;
   logic        out_valid_ff;
   logic [2:0]  kind_ff;
   logic [15:0] pos_ff, dur_ff;
   logic [7:0]  idx_ff;
   logic        last_ff;

   logic        load;
   logic        want_pix, want_mid, want_end;
   logic        pick_last;
   logic [2:0]  pick_kind;
   logic [15:0] pick_pos, pick_dur;
   logic [7:0]  pick_idx;

   assign load     = head_valid && (!out_valid_ff || pop);
   assign want_pix = head.has_pix && !sent_pix_ff;
   assign want_mid = head.has_mid && !sent_mid_ff;
   assign want_end = head.has_end;

   always_comb begin
      pick_kind = lasd_pkg::KIND_END;
      pick_pos  = '0;
      pick_idx  = '0;
      pick_dur  = '0;
      pick_last = 1'b1;
      if (want_pix) begin
         pick_kind = lasd_pkg::KIND_PIXEL;
         pick_pos  = head.pos;
         pick_idx  = head.idx;
         pick_last = !(want_mid || want_end);
      end else if (want_mid) begin
         pick_kind = head.mid_kind;
         pick_dur  = head.dur;
         pick_last = !want_end;
      end
   end

   assign head_pop = load && pick_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sent_pix_ff  <= 1'b0;
         sent_mid_ff  <= 1'b0;
      end else begin
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
         if (head_pop) begin
            sent_pix_ff <= 1'b0;
            sent_mid_ff <= 1'b0;
         end else if (load) begin
            if (want_pix) begin
               sent_pix_ff <= 1'b1;
            end else begin
               sent_mid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= pick_kind;
         pos_ff  <= pick_pos;
         idx_ff  <= pick_idx;
         dur_ff  <= pick_dur;
         last_ff <= pick_last;
      end
   end

   assign empty          = !out_valid_ff;
   assign kind           = kind_ff;
   assign pixel_position = pos_ff;
   assign color_index    = idx_ff;
   assign duration_ms    = dur_ff;
   assign last           = last_ff;

endmodule

// File: hw/rtl/led_animation_stream_decoder_top.sv
// LED animation stream decoder.
// Input channel: one stream byte per beat on req_stream_byte, taken when push
// is high and full is low. Result channel: the oldest event sits on the rsp_
// ports while empty is low and leaves on a clock edge with pop high. Events
// are pixel writes, show markers, delay and fade events and an end event;
// rsp_last marks the final event caused by one byte.
// Configuration: csr_valid/csr_ready with csr_index (0 stream length,
// 1 palette size, 2 pixel total) and csr_data; csr_ready is always high and
// other indexes are ignored. Write only while the block is idle.
// The parser takes one byte per cycle while full is low and hands each byte's
// events, as one bundle, to a small queue; the output side drains one event
// per cycle while pop is high. The first event of a byte passes through the
// queue and then the output register before it reaches the result ports, and
// waits in the queue while the output register is held. The output side
// bounds the sustained rate at one event per cycle, so a byte with three
// events holds it longer than a byte with one.
// full rises when the queue holds QUEUE_DEPTH bundles, which happens only
// while the receiver stalls or events pile up; then bytes wait at the input.
// Synchronous reset clears the parser, the queue and the output register and
// sets the registers to stream length 0, palette size 0, pixel total 1.
module led_animation_stream_decoder_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_stream_byte,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_pixel_position,
   output logic [7:0]  rsp_color_index,
   output logic [15:0] rsp_duration_ms,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic                 accept;
   logic                 bundle_valid;
   lasd_pkg::bundle_type bundle;
   lasd_pkg::bundle_type head;
   logic                 head_valid;
   logic                 head_pop;
   logic                 q_full;

   // A byte is taken whenever the queue has room; bytes that cause no event
   // never enter the queue.
   assign accept    = push && !full;
   assign full      = q_full;
   assign csr_ready = 1'b1;

   lasd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .stream_byte  (req_stream_byte),
      .csr_we       (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .bundle_valid (bundle_valid),
      .bundle       (bundle)
   );

   lasd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (accept && bundle_valid),
      .wr_data   (bundle),
      .rd_en     (head_pop),
      .rd_data   (head),
      .not_empty (head_valid),
      .is_full   (q_full)
   );

   // The output side walks each bundle one event at a time into the output
   // register, so the receiver may stall without holding up the parser until the queue fills.
   lasd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head           (head),
      .head_pop       (head_pop),
      .pop            (pop),
      .empty          (empty),
      .kind           (rsp_kind),
      .pixel_position (rsp_pixel_position),
      .color_index    (rsp_color_index),
      .duration_ms    (rsp_duration_ms),
      .last           (rsp_last)
   );

endmodule

// File: sim/tb_led_animation_stream_decoder_top.sv
`timescale 1ns / 100ps

// Testbench for the LED animation stream decoder.
// A byte-level decoder model runs next to the DUT. Every accepted stream byte is
// decoded into the display events it should cause. Every event popped from the DUT
// is checked against the oldest of those events.
module tb_led_animation_stream_decoder_top;

   // Record type bytes of the frame stream.
   localparam logic [7:0]  TYPE_IMAGE  = 8'h49;   // 'I'
   localparam logic [7:0]  TYPE_PLACED = 8'h50;   // 'P'
   localparam logic [7:0]  TYPE_DELAY  = 8'h44;   // 'D'
   localparam logic [7:0]  TYPE_FADE   = 8'h46;   // 'F'
   // Register index past the end of the register list. The DUT must ignore writes to it.
   localparam logic [1:0]  CSR_SPARE   = 2'd3;
   // Displays with more pixels than this use two-byte positions in placed records.
   localparam logic [15:0] WIDE_POSITION_LIMIT = 16'd256;
   // Cycles allowed for a byte that causes no event to leave the parser.
   localparam int unsigned SETTLE_CYCLES = 8;
   // Stream bytes per random phase.
   localparam int unsigned PHASE_BEATS = 36;

   typedef enum logic [2:0] {
      SEEK_TYPE, READ_COUNT, READ_POS, READ_INDEX, READ_DURATION
   } parse_step_type;

   typedef enum logic [1:0] {REC_IMAGE, REC_PLACED, REC_DELAY, REC_FADE} record_kind_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] pos;
      logic [7:0]  idx;
      logic [15:0] dur;
      logic        last;
   } display_event_type;

   // All DUT inputs have known values from time zero.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        pop = 1'b0;
   logic        csr_valid = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_data = 16'h0000;
   logic        full;
   logic        empty;
   logic        csr_ready;
   logic [2:0]  rsp_kind;
   logic [15:0] rsp_pixel_position;
   logic [7:0]  rsp_color_index;
   logic [15:0] rsp_duration_ms;
   logic        rsp_last;

   // Register values as the decoder model sees them. These are the reset values.
   logic [15:0] stream_len = 16'd0;
   logic [8:0]  palette_len = 9'd0;
   logic [15:0] display_pixels = 16'd1;

   // Parser state of the decoder model.
   parse_step_type  step = SEEK_TYPE;
   record_kind_type rec_kind = REC_IMAGE;
   logic [15:0]     consumed = 16'd0;
   logic [15:0]     remaining = 16'd0;
   logic [15:0]     next_pixel = 16'd0;
   logic [15:0]     field = 16'd0;
   logic            hi_pending = 1'b0;
   logic            ended = 1'b0;

   // Events caused by the byte being decoded, and all events still owed by the DUT.
   display_event_type burst[$];
   display_event_type pending_events[$];

   int unsigned mismatch_count = 0;
   int unsigned bytes_sent = 0;
   // Set during one stretch of the run. While it is set, neither side idles.
   logic        steady_flow = 1'b0;

   led_animation_stream_decoder_top dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_stream_byte    (req_stream_byte),
      .empty              (empty),
      .pop                (pop),
      .rsp_kind           (rsp_kind),
      .rsp_pixel_position (rsp_pixel_position),
      .rsp_color_index    (rsp_color_index),
      .rsp_duration_ms    (rsp_duration_ms),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Decoder model
   // ---------------------------------------------------------------------------

   function automatic void note_event(input logic [2:0] k, input logic [15:0] p,
                                      input logic [7:0] c, input logic [15:0] d);
      burst.push_back({k, p, c, d, 1'b0});
   endfunction

   // A record has just ended. The stream ends here if its length has been used up.
   function automatic void close_record();
      step = SEEK_TYPE;
      hi_pending = 1'b0;
      if (consumed >= stream_len) begin
         note_event(lasd_pkg::KIND_END, 16'd0, 8'd0, 16'd0);
         ended = 1'b1;
      end
   endfunction

   function automatic void decode_byte(input logic [7:0] b);
      logic [15:0] where;
      burst.delete();
      // Once the stream has ended, bytes are taken but cause nothing.
      if (ended) return;
      if (step == SEEK_TYPE && consumed >= stream_len) begin
         // A type byte at or past the length is not consumed. It only ends the stream.
         note_event(lasd_pkg::KIND_END, 16'd0, 8'd0, 16'd0);
         ended = 1'b1;
      end else begin
         if (consumed != 16'hFFFF) consumed++;
         case (step)
            SEEK_TYPE: begin
               hi_pending = 1'b0;
               if (b == TYPE_IMAGE) begin
                  rec_kind = REC_IMAGE;
                  step = READ_COUNT;
               end else if (b == TYPE_PLACED) begin
                  rec_kind = REC_PLACED;
                  step = READ_COUNT;
               end else if (b == TYPE_DELAY) begin
                  rec_kind = REC_DELAY;
                  step = READ_DURATION;
               end else if (b == TYPE_FADE) begin
                  rec_kind = REC_FADE;
                  step = READ_DURATION;
               end else begin
                  // An unknown type byte is a complete record on its own.
                  close_record();
               end
            end
            READ_COUNT: begin
               if (!hi_pending) begin
                  field = {b, 8'h00};
                  hi_pending = 1'b1;
               end else begin
                  field = field | {8'h00, b};
                  hi_pending = 1'b0;
                  remaining = field;
                  next_pixel = 16'd0;
                  if (remaining == 16'd0) begin
                     note_event(lasd_pkg::KIND_SHOW, 16'd0, 8'd0, 16'd0);
                     close_record();
                  end else begin
                     step = (rec_kind == REC_PLACED) ? READ_POS : READ_INDEX;
                  end
               end
            end
            READ_POS: begin
               if (display_pixels > WIDE_POSITION_LIMIT && !hi_pending) begin
                  field = {b, 8'h00};
                  hi_pending = 1'b1;
               end else begin
                  field = hi_pending ? (field | {8'h00, b}) : {8'h00, b};
                  hi_pending = 1'b0;
                  step = READ_INDEX;
               end
            end
            READ_INDEX: begin
               where = (rec_kind == REC_PLACED) ? field : next_pixel;
               if ({1'b0, b} < palette_len) begin
                  note_event(lasd_pkg::KIND_PIXEL, where, b, 16'd0);
               end
               next_pixel++;
               remaining--;
               if (remaining == 16'd0) begin
                  note_event(lasd_pkg::KIND_SHOW, 16'd0, 8'd0, 16'd0);
                  close_record();
               end else begin
                  step = (rec_kind == REC_PLACED) ? READ_POS : READ_INDEX;
               end
            end
            READ_DURATION: begin
               if (!hi_pending) begin
                  field = {b, 8'h00};
                  hi_pending = 1'b1;
               end else begin
                  field = field | {8'h00, b};
                  hi_pending = 1'b0;
                  note_event((rec_kind == REC_FADE) ? lasd_pkg::KIND_FADE
                                                    : lasd_pkg::KIND_DELAY,
                             16'd0, 8'd0, field);
                  close_record();
               end
            end
            default: begin
               step = SEEK_TYPE;
               hi_pending = 1'b0;
            end
         endcase
      end
      if (burst.size() != 0) begin
         burst[burst.size() - 1].last = 1'b1;
         foreach (burst[i]) pending_events.push_back(burst[i]);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------------

   // pop changes on the falling edge. It is low with a chance of about 13 percent,
   // except while the steady stretch runs.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         pop <= steady_flow || ($urandom_range(99) >= 13);
      end
   end

   function automatic void check_event();
      display_event_type seen;
      display_event_type want;
      seen = {rsp_kind, rsp_pixel_position, rsp_color_index, rsp_duration_ms, rsp_last};
      if (pending_events.size() == 0) begin
         if (mismatch_count < 10)
            $display("%0t: unexpected event kind %0d pos %0d index %0d duration %0d last %0b",
                     $time, seen.kind, seen.pos, seen.idx, seen.dur, seen.last);
         mismatch_count++;
      end else begin
         want = pending_events.pop_front();
         if (seen.kind !== want.kind || seen.pos !== want.pos || seen.idx !== want.idx ||
             seen.dur !== want.dur || seen.last !== want.last) begin
            if (mismatch_count < 10) begin
               $display("%0t: event mismatch", $time);
               $display("   expected kind %0d pos %0d index %0d duration %0d last %0b",
                        want.kind, want.pos, want.idx, want.dur, want.last);
               $display("   actual   kind %0d pos %0d index %0d duration %0d last %0b",
                        seen.kind, seen.pos, seen.idx, seen.dur, seen.last);
            end
            mismatch_count++;
         end
      end
   endfunction

   // An event beat completes on a rising edge with pop high and empty low.
   always @(posedge clock) begin
      if (!reset && pop && empty === 1'b0) check_event();
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(255));
   endfunction

   // A stream length that no part of the main run can reach.
   function automatic logic [15:0] roomy_length();
      return 16'($urandom_range(3000, 65535));
   endfunction

   // Drive one byte and wait until it is accepted. Every call starts on a falling edge.
   // push stays high afterwards, so back-to-back bytes keep the input busy. Any caller
   // that pauses the input goes through settle(), which lowers push first.
   // Outside the steady stretch, a random gap with push low comes before one byte in twenty.
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      if (!steady_flow && $urandom_range(99) < 5) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      push <= 1'b1;
      req_stream_byte <= b;
      do @(posedge clock); while (full !== 1'b0);
      decode_byte(b);
      bytes_sent++;
   endtask

   // Send a byte during the random part. A random byte that lands on a count would
   // make the parser swallow thousands of bytes as pixels. So a byte that lands on a
   // count high byte is sent as zero, and a low byte keeps only its three low bits.
   // Well-formed counts pass through unchanged.
   task automatic send_stream_byte(input logic [7:0] b);
      if (step == READ_COUNT && !ended) b = hi_pending ? (b & 8'h07) : 8'h00;
      send_byte(b);
   endtask

   // Let the DUT go idle: the input is quiet, every owed event has been popped, and any
   // byte that caused no event has had time to pass through the parser.
   task automatic settle();
      @(negedge clock);
      push <= 1'b0;
      while (pending_events.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] reg_index, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (reg_index)
         lasd_pkg::CSR_STREAM_LENGTH: stream_len = data;
         lasd_pkg::CSR_PALETTE_SIZE:  palette_len = data[8:0];
         lasd_pkg::CSR_PIXEL_TOTAL:   display_pixels = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Settle the DUT, then write all three registers. The unused upper bits of the
   // palette write carry random values, and the DUT must ignore them.
   task automatic apply_settings(input logic [15:0] len, input logic [8:0] pal,
                                 input logic [15:0] pixels);
      logic [6:0] pad;
      pad = 7'($urandom_range(127));
      settle();
      csr_write(lasd_pkg::CSR_STREAM_LENGTH, len);
      csr_write(lasd_pkg::CSR_PALETTE_SIZE, {pad, pal});
      csr_write(lasd_pkg::CSR_PIXEL_TOTAL, pixels);
   endtask

   // Send one record with random content. Eight in a hundred of the records that can be cut
   // are cut short, and the bytes that follow then land in the wrong fields.
   task automatic send_record();
      int unsigned pick;
      int unsigned count;
      int unsigned i;
      logic        cut;
      logic [7:0]  t;
      pick = $urandom_range(99);
      cut = ($urandom_range(99) < 8);
      if (pick < 14) begin
         do t = any_byte();
         while (t == TYPE_IMAGE || t == TYPE_PLACED || t == TYPE_DELAY || t == TYPE_FADE);
         send_stream_byte(t);
      end else if (pick < 34) begin
         send_stream_byte((pick < 24) ? TYPE_DELAY : TYPE_FADE);
         send_stream_byte(any_byte());
         if (!cut) send_stream_byte(any_byte());
      end else begin
         count = ($urandom_range(99) < 12) ? 0 : $urandom_range(1, 6);
         send_stream_byte((pick < 66) ? TYPE_IMAGE : TYPE_PLACED);
         send_stream_byte(8'h00);
         send_stream_byte(8'(count));
         if (cut && count > 1) count--;
         for (i = 0; i < count; i++) begin
            if (pick >= 66) begin
               if (display_pixels > WIDE_POSITION_LIMIT) send_stream_byte(any_byte());
               send_stream_byte(any_byte());
            end
            send_stream_byte(any_byte());
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // One record of each type, with the field values at their extremes.
   task automatic test_record_types();
      apply_settings(16'hFFFF, 9'd256, 16'd256);
      // An image with a count of zero shows at once.
      send_byte(TYPE_IMAGE);
      send_byte(8'h00);
      send_byte(8'h00);
      // Two pixels with the lowest and the highest index.
      send_byte(TYPE_IMAGE);
      send_byte(8'h00);
      send_byte(8'h02);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(TYPE_DELAY);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(TYPE_FADE);
      send_byte(8'h00);
      send_byte(8'h00);
      // An unknown type byte is a complete record by itself.
      send_byte(8'h00);
      // With 256 pixels the position is still one byte.
      send_byte(TYPE_PLACED);
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(8'hFF);
      send_byte(8'h80);
   endtask

   // Placed record with two-byte positions. The settings change in the middle of the
   // record, and the next position reverts to one byte.
   task automatic test_wide_positions();
      apply_settings(16'd40000, 9'd0, 16'hFFFF);
      send_byte(TYPE_PLACED);
      send_byte(8'h00);
      send_byte(8'h02);
      send_byte(8'hFF);
      send_byte(8'hFF);
      // The palette is empty, so this pixel is skipped.
      send_byte(8'h07);
      apply_settings(16'd40000, 9'd200, 16'd1);
      send_byte(8'h12);
      send_byte(8'hC7);
   endtask

   // Mostly well-formed records with random content, plus some noise bytes. The run
   // goes through several register settings. The stream length always stays far ahead
   // of the byte count, so the stream does not end here.
   task automatic test_random_stream();
      int unsigned phase_no;
      int unsigned start;
      for (phase_no = 0; phase_no < 5; phase_no++) begin
         case (phase_no)
            0: apply_settings(roomy_length(), 9'd256, 16'd257);
            1: apply_settings(16'hFFFF, 9'd0, 16'd1);
            2: begin
               apply_settings(roomy_length(), 9'($urandom_range(1, 255)), 16'hFFFF);
               csr_write(CSR_SPARE, 16'($urandom_range(65535)));
            end
            3: apply_settings(roomy_length(), 9'($urandom_range(256)),
                              16'($urandom_range(1, 65535)));
            default: apply_settings(roomy_length(), 9'd255, 16'd256);
         endcase
         // The second phase is the stretch in which neither side idles.
         steady_flow = (phase_no == 1);
         start = bytes_sent;
         while (bytes_sent - start < PHASE_BEATS) begin
            if ($urandom_range(99) < 12) begin
               repeat ($urandom_range(1, 3)) send_stream_byte(any_byte());
            end else begin
               send_record();
            end
         end
      end
      steady_flow = 1'b0;
   endtask

   // End of stream. The stream can end only once per run, because reset is not applied
   // again. The seed picks the case. Either a record is still running when the length
   // drops to zero and ends by itself, or the length drops to zero between records and
   // the next type byte is refused. After the end, bytes must cause nothing.
   task automatic test_end_of_stream();
      logic past_record;
      past_record = $urandom_range(1);
      while (step != SEEK_TYPE) send_stream_byte(any_byte());
      if (past_record) begin
         send_byte(TYPE_IMAGE);
         send_byte(8'h00);
         send_byte(8'h03);
         apply_settings(16'h0000, 9'd256, 16'd1);
         // The last pixel causes three events: the pixel, the show and the end.
         repeat (3) send_stream_byte(any_byte());
      end else begin
         apply_settings(16'h0000, 9'd256, 16'd1);
         send_byte(TYPE_DELAY);
      end
      repeat (6) send_stream_byte(any_byte());
   endtask

   // ---------------------------------------------------------------------------
   // Sequence and verdict
   // ---------------------------------------------------------------------------

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_record_types();
      test_wide_positions();
      test_random_stream();
      test_end_of_stream();
      // Wait for the last owed events, then leave room to catch any stray ones.
      settle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("led_animation_stream_decoder_top test passed");
      end else begin
         $display("led_animation_stream_decoder_top test failed");
      end
      $finish;
   end

   // A hung handshake, or an event that never arrives, ends the run here.
   initial begin
      #2_000_000;
      $display("led_animation_stream_decoder_top test failed");
      $finish;
   end

endmodule

// File: led_animation_stream_decoder_top.f
hw/rtl/lasd_pkg.sv
hw/rtl/lasd_front.sv
hw/rtl/lasd_queue.sv
hw/rtl/lasd_back.sv
hw/rtl/led_animation_stream_decoder_top.sv
sim/tb_led_animation_stream_decoder_top.sv
